[design/assert_macros.svh]
// Assertion macros shared by the line edit buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/utf8le_pkg.sv]
// Package: command codes, sequencer states and UTF-8 byte decode for the line edit buffer.
`default_nettype none
package utf8le_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam logic [2:0] MAX_INSERT = 3'd4;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_HOME      = 3'd2,
    CMD_END       = 3'd3,
    CMD_LEFT      = 3'd4,
    CMD_RIGHT     = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ      = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_INS_FILL,
    S_SCAN,
    S_DEL_SHIFT,
    S_DEL_DRAIN,
    S_RIGHT,
    S_READ
  } state_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0) begin
      n = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      n = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      n = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[design/utf8le_ram.sv]
// Line byte store: one write port, one read port with registered read data.
`default_nettype none
module utf8le_ram #(
  parameter int DEPTH = utf8le_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/utf8_line_edit_buffer.sv]
// Top level: UTF-8 line edit buffer with a byte-serial shift and scan sequencer.
//
// Usage: drive cmd and its operands with start high; the command is taken at
// a clock edge where start is high and busy is low. Every command returns one
// result: done pulses high for exactly one cycle with status, cursor_now,
// length_now and read_data valid. The receiver cannot stall; done is never
// repeated, so sample it when it arrives.
// Steps per command (L = length, C = cursor, n = byte_count):
//   home, end, clear, rejected commands, read at or past length: result in the cycle after accept.
//   read, right: one registered line store read before the result.
//   left: a scan back from the cursor over the bytes of the character stepped over.
//   insert: with the cursor at the end of the line, the fill of n bytes only; else the tail
//   shift from L - 1 down to C, a drain state, then the fill, tail moved one byte per cycle.
//   backspace: as left, then when C < L a tail shift of L - C bytes and a drain state.
// One line store port pair serves every step, so an insert or backspace at
// the start of a full line moves the whole line through it byte by byte.
// busy is high from accept until the result is registered, and stays low for the
// commands answered from idle; the next command may be taken in the cycle done is high.
// Reset clears length and cursor; line bytes are not cleared and need no pass.
`default_nettype none
`include "assert_macros.svh"
module utf8_line_edit_buffer #(
  parameter int CAPACITY = utf8le_pkg::CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] cmd,
  input  wire logic [2:0] byte_count,
  input  wire logic [7:0] insert_byte0,
  input  wire logic [7:0] insert_byte1,
  input  wire logic [7:0] insert_byte2,
  input  wire logic [7:0] insert_byte3,
  input  wire logic [7:0] read_index,
  output logic            done,
  output logic            status,
  output logic      [7:0] cursor_now,
  output logic      [7:0] length_now,
  output logic      [7:0] read_data
);

  import utf8le_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (AW > 8) ? AW : 8;
  localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

  state_t state, state_next;
  cmd_t   op, op_next;

  logic [AW-1:0] length, length_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] dptr, dptr_next;
  logic [AW-1:0] waddr, waddr_next;
  logic          pend, pend_next;
  logic [1:0]    k, k_next;
  logic [2:0]    cnt, cnt_next;
  logic [7:0]    ins_bytes [4];

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          fin;
  logic          fin_status;
  logic [7:0]    fin_rdata;

  logic [AW:0]   ins_sum;
  logic [CW-1:0] ridx_ext;
  logic [AW:0]   right_sum;
  logic [CW-1:0] cursor_ext;
  logic [CW-1:0] length_ext;

  assign busy      = (state != S_IDLE);
  assign ins_sum   = (AW+1)'(length) + (AW+1)'(byte_count);
  assign ridx_ext  = CW'(read_index);
  assign right_sum = (AW+1)'(cursor) + (AW+1)'(lead_len(mem_rdata));

  utf8le_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next  = state;
    op_next     = op;
    length_next = length;
    cursor_next = cursor;
    ptr_next    = ptr;
    dptr_next   = dptr;
    waddr_next  = waddr;
    pend_next   = 1'b0;
    k_next      = k;
    cnt_next    = cnt;
    fin         = 1'b0;
    fin_status  = 1'b0;
    fin_rdata   = '0;
    mem_raddr   = ptr;
    mem_we      = pend;
    mem_waddr   = waddr;
    mem_wdata   = mem_rdata;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = cmd_t'(cmd);
          cnt_next = byte_count;
          k_next   = '0;
          unique case (cmd_t'(cmd)) inside
            CMD_INSERT: begin
              if (byte_count > MAX_INSERT || ins_sum >= CAP_W) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else if (byte_count == '0) begin
                fin = 1'b1;
              end else if (cursor == length) begin
                state_next = S_INS_FILL;
              end else begin
                ptr_next   = length - 1'b1;
                state_next = S_INS_SHIFT;
              end
            end
            CMD_BACKSPACE, CMD_LEFT: begin
              if (cursor == '0) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else begin
                mem_raddr  = cursor - 1'b1;
                ptr_next   = cursor - 1'b1;
                state_next = S_SCAN;
              end
            end
            CMD_HOME: begin
              cursor_next = '0;
              fin         = 1'b1;
            end
            CMD_END: begin
              cursor_next = length;
              fin         = 1'b1;
            end
            CMD_RIGHT: begin
              if (cursor >= length) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else begin
                mem_raddr  = cursor;
                state_next = S_RIGHT;
              end
            end
            CMD_CLEAR: begin
              length_next = '0;
              cursor_next = '0;
              fin         = 1'b1;
            end
            CMD_READ: begin
              if (ridx_ext < CW'(length)) begin
                mem_raddr  = ridx_ext[AW-1:0];
                state_next = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        mem_raddr  = ptr;
        pend_next  = 1'b1;
        waddr_next = ptr + AW'(cnt);
        if (ptr == cursor) begin
          state_next = S_INS_DRAIN;
        end else begin
          ptr_next = ptr - 1'b1;
        end
      end
      S_INS_DRAIN: begin
        state_next = S_INS_FILL;
      end
      S_INS_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cursor + AW'(k);
        mem_wdata = ins_bytes[k];
        k_next    = k + 1'b1;
        if (({1'b0, k} + 3'd1) == cnt) begin
          length_next = length + AW'(cnt);
          cursor_next = cursor + AW'(cnt);
          fin         = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ptr != '0 && is_cont(mem_rdata)) begin
          ptr_next  = ptr - 1'b1;
          mem_raddr = ptr - 1'b1;
        end else if (op == CMD_LEFT) begin
          cursor_next = ptr;
          fin         = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cursor_next = ptr;
          length_next = length - cursor + ptr;
          dptr_next   = ptr;
          ptr_next    = cursor;
          if (cursor == length) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_DEL_SHIFT;
          end
        end
      end
      S_DEL_SHIFT: begin
        mem_raddr  = ptr;
        pend_next  = 1'b1;
        waddr_next = dptr;
        dptr_next  = dptr + 1'b1;
        if (dptr == length - 1'b1) begin
          state_next = S_DEL_DRAIN;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_DEL_DRAIN: begin
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_RIGHT: begin
        if (right_sum > (AW+1)'(length)) begin
          cursor_next = length;
        end else begin
          cursor_next = right_sum[AW-1:0];
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        fin_rdata  = mem_rdata;
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
      cursor <= '0;
      pend   <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      cursor <= cursor_next;
      pend   <= pend_next;
      done   <= fin;
    end
  end

  assign cursor_ext = CW'(cursor_next);
  assign length_ext = CW'(length_next);

  always_ff @(posedge clk) begin
    op    <= op_next;
    ptr   <= ptr_next;
    dptr  <= dptr_next;
    waddr <= waddr_next;
    k     <= k_next;
    cnt   <= cnt_next;
    if (state == S_IDLE && start) begin
      ins_bytes[0] <= insert_byte0;
      ins_bytes[1] <= insert_byte1;
      ins_bytes[2] <= insert_byte2;
      ins_bytes[3] <= insert_byte3;
    end
    if (fin) begin
      status     <= fin_status;
      cursor_now <= cursor_ext[7:0];
      length_now <= length_ext[7:0];
      read_data  <= fin_rdata;
    end
  end

  `ASSERT_ALWAYS(a_cursor_in_line, clk, rst, cursor <= length, "cursor beyond line length")
  `ASSERT_ALWAYS(a_length_below_cap, clk, rst, (AW+1)'(length) < CAP_W, "line length at capacity")
  `ASSERT_ALWAYS(a_done_when_free, clk, rst, !(done && busy), "result while still busy")
  `ASSERT_ALWAYS(a_no_write_clash, clk, rst, !(pend && state == S_INS_FILL), "tail move and fill collide")
  `ASSERT_NEXT(a_clear_quick, clk, rst, state == S_IDLE && start && cmd == CMD_CLEAR, done && length_now == 8'd0, "clear not answered next cycle")

endmodule
`default_nettype wire
